// ===== hdl/fifo_queue_lock_manager_defines.svh =====
// Assertion helpers used by the checker file.
`ifndef FIFO_QUEUE_LOCK_MANAGER_DEFINES_SVH
`define FIFO_QUEUE_LOCK_MANAGER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define FQLM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lock manager check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define FQLM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lock manager check failed");

`endif

// ===== hdl/fqlm_pkg.sv =====
package fqlm_pkg;

    // Payload widths
    localparam int CMD_W    = 1;
    localparam int ID_W     = 6;
    localparam int STATUS_W = 3;

    // Default size of the requester population
    localparam int NUM_REQUESTERS_DEF = 64;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ACQUIRE = 1'b0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_GRANTED = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_QUEUED  = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_FREED   = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_HANDED  = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_ERROR   = 3'd4;

endpackage

// ===== hdl/fqlm_if.sv =====
// Request channel: one acquire or release beat per handshake.
interface fqlm_req_if;
    logic                        valid;
    logic                        ready;
    logic [fqlm_pkg::CMD_W-1:0]  cmd;
    logic [fqlm_pkg::ID_W-1:0]   requester;

    modport source (output valid, output cmd, output requester, input ready);
    modport sink   (input valid, input cmd, input requester, output ready);
endinterface

// Result channel: one status beat per request.
interface fqlm_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [fqlm_pkg::STATUS_W-1:0] status;
    logic [fqlm_pkg::ID_W-1:0]     granted_id;

    modport source (output valid, output status, output granted_id, input ready);
    modport sink   (input valid, input status, input granted_id, output ready);
endinterface

// ===== hdl/fifo_queue_lock_manager.sv =====
// MCS-style queue lock manager for one lock shared by NUM_REQUESTERS agents.
// Each request beat is an acquire or a release; each produces exactly one
// result beat (granted, queued, freed, handed over, or error). Waiters are
// served in arrival order through a per-requester successor link held in a
// synchronous RAM. A request is accepted in ST_IDLE, where the successor RAM
// is read at the requester's entry, and is then resolved in ST_EXEC, where the
// RAM and the tail, holder and flag registers are written back and the
// result is loaded into the output register. The request channel is ready
// again in the cycle after resolution, even while the result still waits; if
// the result register is still held by a stalled sink, resolution waits for
// it. Requester ids at or above NUM_REQUESTERS are answered with an error.
// No clearing pass is needed after reset.
module fifo_queue_lock_manager #(
    parameter int NUM_REQUESTERS = fqlm_pkg::NUM_REQUESTERS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    fqlm_req_if.sink      req,
    fqlm_rsp_if.source    rsp
);

    localparam int IDX_W = $clog2(NUM_REQUESTERS);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;

    // Captured request
    logic [fqlm_pkg::CMD_W-1:0] cmd_reg, cmd_next;
    logic [fqlm_pkg::ID_W-1:0]  req_id_reg, req_id_next;

    // Lock state
    logic                       tail_valid_reg, tail_valid_next;
    logic [fqlm_pkg::ID_W-1:0]  tail_id_reg, tail_id_next;
    logic                       holder_valid_reg, holder_valid_next;
    logic [fqlm_pkg::ID_W-1:0]  holder_id_reg, holder_id_next;
    logic [NUM_REQUESTERS-1:0]  succ_valid_reg, succ_valid_next;
    logic [NUM_REQUESTERS-1:0]  waiting_reg, waiting_next;

    // Successor id RAM
    logic [fqlm_pkg::ID_W-1:0]  succ_mem [NUM_REQUESTERS];
    logic [fqlm_pkg::ID_W-1:0]  succ_rd_reg;
    logic                       mem_we;
    logic [IDX_W-1:0]           mem_waddr;
    logic [IDX_W-1:0]           rd_idx;

    // Result register
    logic                          out_valid_reg, out_valid_next;
    logic [fqlm_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [fqlm_pkg::ID_W-1:0]     gid_reg, gid_next;

    logic             in_range;
    logic             holding;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] tail_idx;
    logic [IDX_W-1:0] succ_idx;

    assign req.ready      = (state_reg == ST_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = status_reg;
    assign rsp.granted_id = gid_reg;

    assign rd_idx   = IDX_W'(req.requester);
    assign r_idx    = IDX_W'(req_id_reg);
    assign tail_idx = IDX_W'(tail_id_reg);
    assign succ_idx = IDX_W'(succ_rd_reg);
    assign in_range = (32'(req_id_reg) < NUM_REQUESTERS);
    assign holding  = holder_valid_reg && (holder_id_reg == req_id_reg);
    assign mem_waddr = tail_idx;

    // Resolve the captured request against the lock state
    always_comb
    begin
        state_next        = state_reg;
        cmd_next          = cmd_reg;
        req_id_next       = req_id_reg;
        tail_valid_next   = tail_valid_reg;
        tail_id_next      = tail_id_reg;
        holder_valid_next = holder_valid_reg;
        holder_id_next    = holder_id_reg;
        succ_valid_next   = succ_valid_reg;
        waiting_next      = waiting_reg;
        mem_we            = 1'b0;
        out_valid_next    = out_valid_reg && !rsp.ready;
        status_next       = status_reg;
        gid_next          = gid_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next    = req.cmd;
                    req_id_next = req.requester;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    status_next    = fqlm_pkg::STATUS_ERROR;
                    gid_next       = '0;
                    if (!in_range)
                    begin
                        status_next = fqlm_pkg::STATUS_ERROR;
                    end
                    else if (cmd_reg == fqlm_pkg::CMD_ACQUIRE)
                    begin
                        if (!holding && !waiting_reg[r_idx])
                        begin
                            succ_valid_next[r_idx] = 1'b0;
                            if (!tail_valid_reg)
                            begin
                                // Free lock: grant at once
                                tail_valid_next   = 1'b1;
                                tail_id_next      = req_id_reg;
                                holder_valid_next = 1'b1;
                                holder_id_next    = req_id_reg;
                                status_next       = fqlm_pkg::STATUS_GRANTED;
                                gid_next          = req_id_reg;
                            end
                            else
                            begin
                                // Link behind the tail and wait
                                succ_valid_next[tail_idx] = 1'b1;
                                mem_we                    = 1'b1;
                                tail_id_next              = req_id_reg;
                                waiting_next[r_idx]       = 1'b1;
                                status_next               = fqlm_pkg::STATUS_QUEUED;
                            end
                        end
                    end
                    else if (holding)
                    begin
                        if (succ_valid_reg[r_idx])
                        begin
                            // Hand over to the next waiter
                            succ_valid_next[r_idx]  = 1'b0;
                            holder_id_next          = succ_rd_reg;
                            waiting_next[succ_idx]  = 1'b0;
                            status_next             = fqlm_pkg::STATUS_HANDED;
                            gid_next                = succ_rd_reg;
                        end
                        else
                        begin
                            // No waiter: free the lock
                            tail_valid_next   = 1'b0;
                            tail_id_next      = '0;
                            holder_valid_next = 1'b0;
                            holder_id_next    = '0;
                            status_next       = fqlm_pkg::STATUS_FREED;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and lock state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            tail_valid_reg   <= 1'b0;
            tail_id_reg      <= '0;
            holder_valid_reg <= 1'b0;
            holder_id_reg    <= '0;
            succ_valid_reg   <= '0;
            waiting_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            tail_valid_reg   <= tail_valid_next;
            tail_id_reg      <= tail_id_next;
            holder_valid_reg <= holder_valid_next;
            holder_id_reg    <= holder_id_next;
            succ_valid_reg   <= succ_valid_next;
            waiting_reg      <= waiting_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        req_id_reg <= req_id_next;
        status_reg <= status_next;
        gid_reg    <= gid_next;
    end

    // Successor RAM: read at accept, write back on enqueue
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            succ_rd_reg <= succ_mem[rd_idx];
        end
        if (mem_we)
        begin
            succ_mem[mem_waddr] <= req_id_reg;
        end
    end

endmodule

// ===== hdl/fqlm_checker.sv =====
`include "fifo_queue_lock_manager_defines.svh"

module fqlm_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [fqlm_pkg::STATUS_W-1:0] rsp_status,
    input logic [fqlm_pkg::ID_W-1:0]     rsp_granted_id
);

    logic req_take;
    logic rsp_stall;
    logic no_id_status;

    assign req_take     = req_valid && req_ready;
    assign rsp_stall    = rsp_valid && !rsp_ready;
    assign no_id_status = rsp_valid
                          && (rsp_status != fqlm_pkg::STATUS_GRANTED)
                          && (rsp_status != fqlm_pkg::STATUS_HANDED);

    // Hold a stalled result beat
    `FQLM_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable({rsp_status, rsp_granted_id}))

    // Take no request in the cycle after one was taken
    `FQLM_ASSERT_NEXT(a_no_back_to_back, req_take, !req_ready)

    // Raise a result only after a resolve cycle with requests held off
    `FQLM_ASSERT_NOW(a_rsp_after_resolve, $rose(rsp_valid), !$past(req_ready))

    // Report an id only for a grant or a hand-over
    `FQLM_ASSERT_NOW(a_gid_zero, no_id_status, rsp_granted_id == '0)

endmodule

bind fifo_queue_lock_manager fqlm_checker u_fqlm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_status     (rsp.status),
    .rsp_granted_id (rsp.granted_id)
);
